>>> rtl/clip_pkg.sv
// Shared types and constants for the config line id parser.
// Used by clip_front, clip_fifo, clip_back and config_line_id_parser_top.
// No dependencies.
package clip_pkg;

    // character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_S  = 8'h73;
    localparam logic [7:0] CH_LC_V  = 8'h76;

    // id layout: 16 hex digits, colon, 16 hex digits
    localparam logic [5:0] ID_CHARS  = 6'd33;
    localparam logic [5:0] COLON_POS = 6'd16;
    localparam logic [7:0] LEN_SAT   = 8'd255;

    // token queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // result codes
    localparam logic [1:0] DIR_NO_EQ = 2'd0;
    localparam logic [1:0] DIR_OTHER = 2'd1;
    localparam logic [1:0] DIR_INIT  = 2'd2;
    localparam logic [1:0] DIR_BSV   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    // key letters the matcher cares about
    typedef enum logic [2:0] {
        KC_I,
        KC_N,
        KC_T,
        KC_B,
        KC_S,
        KC_V,
        KC_OTHER
    } key_chr_t;

    // classified character, one per accepted byte
    typedef struct packed {
        logic       is_nl;
        logic       eod;
        logic       is_eq;
        logic       is_colon;
        logic       hex_ok;
        logic [3:0] hex_val;
        key_chr_t   kc;
    } token_t;

    // key matcher states
    typedef enum logic [8:0] {
        KM_START = 9'b000000001,
        KM_I     = 9'b000000010,
        KM_IN    = 9'b000000100,
        KM_INI   = 9'b000001000,
        KM_INIT  = 9'b000010000,
        KM_B     = 9'b000100000,
        KM_BS    = 9'b001000000,
        KM_BSV   = 9'b010000000,
        KM_MISS  = 9'b100000000
    } km_state_t;

endpackage

>>> rtl/config_line_id_parser_top.sv
// Top level of the config line id parser: front classifier, token queue, line parser.
// Depends on clip_pkg, clip_front, clip_fifo and clip_back.
//
// Usage:
//   Slave channel carries configuration text, one byte per transfer:
//   s_tdata[7:0] is the character, s_tlast marks the last byte of the data
//   and closes the open line. Byte 0x0A ends a line as well.
//   Master channel carries one transfer per non-empty line: m_tuser holds
//   the directive kind (no '=', other key, init, bsv) and the status (ok,
//   malformed id, line too long); m_tdata holds the 128-bit id, which is
//   zero unless the status is ok and the key is init or bsv.
// Throughput: one byte per cycle, sustained, as long as m_tready keeps up;
//   the parser consumes one queued token per cycle and each token only
//   touches small counters and a 4-bit shift of the id accumulators.
// Result path: a line-closing byte is written into the token queue and, once
//   at its head, is judged into the registered result slot behind m_tvalid.
// Stall: while a result waits on m_tready the parser holds, the 4-entry
//   token queue keeps taking bytes, and s_tready drops once it is full.
// Reset: rst_n clears the queue, the line state and the result slot;
//   s_tready is high from the first cycle after reset.
module config_line_id_parser_top #(
    parameter int MAX_LINE = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic   [7:0] s_tdata,    // [7:0] text_byte
    input  logic         s_tlast,    // end_of_data
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,    // [63:0] id_high, [127:64] id_low
    output logic   [3:0] m_tuser     // [1:0] directive, [3:2] status
);
    import clip_pkg::*;

    token_t               in_token;
    token_t               head_token;
    logic                 fifo_full;
    logic                 fifo_not_empty;
    logic                 fifo_pop;
    logic                 in_xfer;
    logic [FIFO_CW-1:0]   fifo_count;
    logic [1:0]           res_dir;
    logic [1:0]           res_st;
    logic [63:0]          res_hi;
    logic [63:0]          res_lo;

    assign s_tready = !fifo_full;
    assign in_xfer  = s_tvalid && s_tready;

    clip_front u_front (
        .text_byte   (s_tdata),
        .end_of_data (s_tlast),
        .token       (in_token)
    );

    clip_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_xfer),
        .push_token (in_token),
        .full       (fifo_full),
        .pop        (fifo_pop),
        .not_empty  (fifo_not_empty),
        .head       (head_token),
        .count      (fifo_count)
    );

    clip_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_valid     (fifo_not_empty),
        .tok           (head_token),
        .tok_pop       (fifo_pop),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res_directive (res_dir),
        .res_status    (res_st),
        .res_id_high   (res_hi),
        .res_id_low    (res_lo)
    );

    assign m_tdata = {res_lo, res_hi};
    assign m_tuser = {res_st, res_dir};

    // queue never overflows nor underflows
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("token queue count out of range");

    // a nonzero id only comes with an ok init or bsv line
    a_id_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata != '0) |-> (m_tuser[3:2] == ST_OK) && m_tuser[1])
        else $error("id reported on a line without a good id");

    // malformed status belongs to init or bsv only
    a_malformed_dir: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[3:2] == ST_MALFORMED) |-> m_tuser[1])
        else $error("malformed status on a line that takes no id");

    // status code is never the unused value
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[3:2] != 2'd3))
        else $error("unused status code");

endmodule

>>> rtl/clip_front.sv
// Front end: classifies each input byte into a token for the queue.
// Depends on clip_pkg.
module clip_front (
    input  logic            [7:0] text_byte,
    input  logic                  end_of_data,
    output clip_pkg::token_t      token
);
    import clip_pkg::*;

    logic is_digit;
    logic is_lc_hex;
    logic is_uc_hex;

    always_comb
    begin
        is_digit  = (text_byte >= 8'h30) && (text_byte <= 8'h39);
        is_lc_hex = (text_byte >= 8'h61) && (text_byte <= 8'h66);
        is_uc_hex = (text_byte >= 8'h41) && (text_byte <= 8'h46);

        token.is_nl    = (text_byte == CH_NL);
        token.eod      = end_of_data;
        token.is_eq    = (text_byte == CH_EQ);
        token.is_colon = (text_byte == CH_COLON);
        token.hex_ok   = is_digit || is_lc_hex || is_uc_hex;
        // letters: low nibble 1..6 maps to 10..15
        token.hex_val  = is_digit ? text_byte[3:0] : (text_byte[3:0] + 4'd9);

        unique case (text_byte)
            CH_LC_I: token.kc = KC_I;
            CH_LC_N: token.kc = KC_N;
            CH_LC_T: token.kc = KC_T;
            CH_LC_B: token.kc = KC_B;
            CH_LC_S: token.kc = KC_S;
            CH_LC_V: token.kc = KC_V;
            default: token.kc = KC_OTHER;
        endcase
    end

endmodule

>>> rtl/clip_fifo.sv
// Short token queue decoupling the front end from the line parser.
// Depends on clip_pkg.
module clip_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  clip_pkg::token_t              push_token,
    output logic                          full,
    input  logic                          pop,
    output logic                          not_empty,
    output clip_pkg::token_t              head,
    output logic [clip_pkg::FIFO_CW-1:0]  count
);
    import clip_pkg::*;

    token_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = push ? FIFO_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? FIFO_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = FIFO_CW'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = FIFO_CW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_token;
    end

    assign full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

>>> rtl/clip_back.sv
// Back end: per-line parser state and the registered result slot.
// Depends on clip_pkg; tokens come from clip_fifo.
module clip_back #(
    parameter int MAX_LINE = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  clip_pkg::token_t  tok,
    output logic              tok_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output logic       [1:0]  res_directive,
    output logic       [1:0]  res_status,
    output logic      [63:0]  res_id_high,
    output logic      [63:0]  res_id_low
);
    import clip_pkg::*;

    localparam logic [7:0] LenLimit = 8'(MAX_LINE);

    function automatic km_state_t next_key(km_state_t k, key_chr_t c);
        km_state_t r;
        r = KM_MISS;
        unique case (k)
            KM_START:
            begin
                if (c == KC_I)
                    r = KM_I;
                else if (c == KC_B)
                    r = KM_B;
            end
            KM_I:    if (c == KC_N) r = KM_IN;
            KM_IN:   if (c == KC_I) r = KM_INI;
            KM_INI:  if (c == KC_T) r = KM_INIT;
            KM_B:    if (c == KC_S) r = KM_BS;
            KM_BS:   if (c == KC_V) r = KM_BSV;
            default: r = KM_MISS;
        endcase
        return r;
    endfunction

    // line state
    logic        phase_reg;
    logic        phase_next;
    km_state_t   km_reg;
    km_state_t   km_next;
    logic [7:0]  len_reg;
    logic [7:0]  len_next;
    logic [5:0]  vidx_reg;
    logic [5:0]  vidx_next;
    logic [63:0] acc_hi_reg;
    logic [63:0] acc_hi_next;
    logic [63:0] acc_lo_reg;
    logic [63:0] acc_lo_next;
    logic        err_reg;
    logic        err_next;

    // result slot
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_dir_reg;
    logic [1:0]  out_dir_next;
    logic [1:0]  out_st_reg;
    logic [1:0]  out_st_next;
    logic [63:0] out_hi_reg;
    logic [63:0] out_hi_next;
    logic [63:0] out_lo_reg;
    logic [63:0] out_lo_next;

    // state after taking the token as a character
    logic        t_phase;
    km_state_t   t_km;
    logic [7:0]  t_len;
    logic [5:0]  t_vidx;
    logic [63:0] t_hi;
    logic [63:0] t_lo;
    logic        t_err;

    // state the line is closed with
    logic        c_phase;
    km_state_t   c_km;
    logic [7:0]  c_len;
    logic [5:0]  c_vidx;
    logic        c_err;

    logic        out_free;
    logic        closing;
    logic        emit;
    logic [1:0]  dir;
    logic [1:0]  st;

    always_comb
    begin
        t_phase = phase_reg;
        t_km    = km_reg;
        t_len   = (len_reg == LEN_SAT) ? len_reg : 8'(len_reg + 1'b1);
        t_vidx  = vidx_reg;
        t_hi    = acc_hi_reg;
        t_lo    = acc_lo_reg;
        t_err   = err_reg;

        if (!phase_reg)
        begin
            if (tok.is_eq)
                t_phase = 1'b1;
            else
                t_km = next_key(km_reg, tok.kc);
        end
        else if (vidx_reg < ID_CHARS)
        begin
            if (vidx_reg == COLON_POS)
            begin
                if (!tok.is_colon)
                    t_err = 1'b1;
            end
            else if (!tok.hex_ok)
                t_err = 1'b1;
            else if (vidx_reg < COLON_POS)
                t_hi = {acc_hi_reg[59:0], tok.hex_val};
            else
                t_lo = {acc_lo_reg[59:0], tok.hex_val};
            t_vidx = 6'(vidx_reg + 1'b1);
        end

        // a newline only terminates; any other byte joins the line first
        if (tok.is_nl)
        begin
            c_phase = phase_reg;
            c_km    = km_reg;
            c_len   = len_reg;
            c_vidx  = vidx_reg;
            c_err   = err_reg;
        end
        else
        begin
            c_phase = t_phase;
            c_km    = t_km;
            c_len   = t_len;
            c_vidx  = t_vidx;
            c_err   = t_err;
        end

        if (!c_phase)
            dir = DIR_NO_EQ;
        else if (c_km == KM_INIT)
            dir = DIR_INIT;
        else if (c_km == KM_BSV)
            dir = DIR_BSV;
        else
            dir = DIR_OTHER;

        if (c_len >= LenLimit)
            st = ST_TOO_LONG;
        else if (dir[1] && (c_err || (c_vidx < ID_CHARS)))
            st = ST_MALFORMED;
        else
            st = ST_OK;

        out_free = !out_valid_reg || res_ready;
        tok_pop  = tok_valid && out_free;
        closing  = tok.is_nl || tok.eod;
        emit     = tok_pop && closing && (c_len != 8'd0);

        phase_next  = phase_reg;
        km_next     = km_reg;
        len_next    = len_reg;
        vidx_next   = vidx_reg;
        acc_hi_next = acc_hi_reg;
        acc_lo_next = acc_lo_reg;
        err_next    = err_reg;
        if (tok_pop)
        begin
            if (closing)
            begin
                phase_next  = 1'b0;
                km_next     = KM_START;
                len_next    = '0;
                vidx_next   = '0;
                acc_hi_next = '0;
                acc_lo_next = '0;
                err_next    = 1'b0;
            end
            else
            begin
                phase_next  = t_phase;
                km_next     = t_km;
                len_next    = t_len;
                vidx_next   = t_vidx;
                acc_hi_next = t_hi;
                acc_lo_next = t_lo;
                err_next    = t_err;
            end
        end

        out_valid_next = out_free ? emit : out_valid_reg;
        out_dir_next   = out_dir_reg;
        out_st_next    = out_st_reg;
        out_hi_next    = out_hi_reg;
        out_lo_next    = out_lo_reg;
        if (emit)
        begin
            out_dir_next = dir;
            out_st_next  = st;
            // ids only when the line's own accumulators hold a good id
            out_hi_next  = (st == ST_OK && dir[1]) ? (tok.is_nl ? acc_hi_reg : t_hi) : '0;
            out_lo_next  = (st == ST_OK && dir[1]) ? (tok.is_nl ? acc_lo_reg : t_lo) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            km_reg        <= KM_START;
            len_reg       <= '0;
            vidx_reg      <= '0;
            acc_hi_reg    <= '0;
            acc_lo_reg    <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            km_reg        <= km_next;
            len_reg       <= len_next;
            vidx_reg      <= vidx_next;
            acc_hi_reg    <= acc_hi_next;
            acc_lo_reg    <= acc_lo_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dir_reg <= out_dir_next;
        out_st_reg  <= out_st_next;
        out_hi_reg  <= out_hi_next;
        out_lo_reg  <= out_lo_next;
    end

    assign res_valid     = out_valid_reg;
    assign res_directive = out_dir_reg;
    assign res_status    = out_st_reg;
    assign res_id_high   = out_hi_reg;
    assign res_id_low    = out_lo_reg;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for config_line_id_parser_top: drives config text byte by byte and
// checks each line report against a built-in line parser model or a hand-typed report.
// Depends on clip_pkg and the RTL under rtl/.
module tb_top;
    import clip_pkg::*;

    localparam int LINE_LIMIT   = 128;      // MAX_LINE given to the parser
    localparam int RAND_BYTES   = 640;      // random text, split over the idle phases
    localparam int DRAIN_CYCLES = 20;       // quiet time after the last report
    localparam int CYCLE_LIMIT  = 400000;   // hard stop, far above the slowest run

    // idle phases: none, source gaps, sink stalls, light gaps on both sides
    localparam int SRC_IDLE  [4] = '{0, 87, 0, 7};
    localparam int SNK_STALL [4] = '{0, 0, 87, 7};

    // one line report as it leaves the block
    typedef struct packed {
        logic [1:0]  dir;
        logic [1:0]  st;
        logic [63:0] id_hi;
        logic [63:0] id_lo;
    } line_report_t;

    // how a line is closed
    typedef enum {END_NL, END_EOD, END_NL_EOD} line_end_t;

    // directed rows: text, filler count and byte, line end, and a hand-typed
    // report where it is obvious from the spec; other rows use the model
    typedef struct {
        string        text;
        int           pad;
        logic [7:0]   pad_ch;
        line_end_t    term;
        bit           typed;
        line_report_t want;
    } dir_row_t;

    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] HI_A = 64'h0123_4567_89ab_cdef;
    localparam logic [63:0] LO_A = 64'hfedc_ba98_7654_3210;

    dir_row_t dir_rows [25] = '{
        // plain init and bsv lines, id extremes
        '{"init=0123456789abcdef:FEDCBA9876543210", 0, 8'h78, END_NL, 1,
          '{DIR_INIT, ST_OK, HI_A, LO_A}},
        '{"bsv=FFFFFFFFFFFFFFFF:0000000000000000", 0, 8'h78, END_NL, 1,
          '{DIR_BSV, ST_OK, ONES, 64'h0}},
        '{"bsv=0000000000000000:ffffffffffffffff", 0, 8'h78, END_NL, 1,
          '{DIR_BSV, ST_OK, 64'h0, ONES}},
        // empty line: no report at all
        '{"", 0, 8'h78, END_NL, 0, '0},
        // key without '='
        '{"init", 0, 8'h78, END_NL, 1, '{DIR_NO_EQ, ST_OK, 64'h0, 64'h0}},
        // other keys: no id check, ids zero
        '{"initx=0123456789abcdef:FEDCBA9876543210", 0, 8'h78, END_NL, 1,
          '{DIR_OTHER, ST_OK, 64'h0, 64'h0}},
        '{"ini=0123456789abcdef:FEDCBA9876543210", 0, 8'h78, END_NL, 1,
          '{DIR_OTHER, ST_OK, 64'h0, 64'h0}},
        '{"=", 0, 8'h78, END_NL, 1, '{DIR_OTHER, ST_OK, 64'h0, 64'h0}},
        // short value
        '{"bsv=0123", 0, 8'h78, END_NL, 1, '{DIR_BSV, ST_MALFORMED, 64'h0, 64'h0}},
        // hex digit where the colon belongs
        '{"init=0123456789abcdef00123456789abcdef", 0, 8'h78, END_NL, 1,
          '{DIR_INIT, ST_MALFORMED, 64'h0, 64'h0}},
        // colon in the wrong place
        '{"bsv=012345678:abcdef:0123456789abcdef", 0, 8'h78, END_NL, 1,
          '{DIR_BSV, ST_MALFORMED, 64'h0, 64'h0}},
        // trailing junk after the id is ignored, later '=' too
        '{"init=0123456789abcdef:FEDCBA9876543210=tail;!", 0, 8'h78, END_NL, 1,
          '{DIR_INIT, ST_OK, HI_A, LO_A}},
        // later '=' inside the id field
        '{"bsv=0123456789abcdef:0123456789abcde=", 0, 8'h78, END_NL, 1,
          '{DIR_BSV, ST_MALFORMED, 64'h0, 64'h0}},
        '{"a=b=c", 0, 8'h78, END_NL, 1, '{DIR_OTHER, ST_OK, 64'h0, 64'h0}},
        // one below the length limit, at the limit, and far past saturation
        '{"init=0123456789abcdef:FEDCBA9876543210", 89, 8'h78, END_NL, 1,
          '{DIR_INIT, ST_OK, HI_A, LO_A}},
        '{"init=0123456789abcdef:FEDCBA9876543210", 90, 8'h78, END_NL, 1,
          '{DIR_INIT, ST_TOO_LONG, 64'h0, 64'h0}},
        '{"b", 300, 8'h79, END_NL, 1, '{DIR_NO_EQ, ST_TOO_LONG, 64'h0, 64'h0}},
        // newline flagged as last byte, then an ordinary last byte
        '{"bsv=0123456789abcdef:FEDCBA9876543210", 0, 8'h78, END_NL_EOD, 1,
          '{DIR_BSV, ST_OK, HI_A, LO_A}},
        '{"init=0123456789abcdef:FEDCBA9876543210", 0, 8'h78, END_EOD, 1,
          '{DIR_INIT, ST_OK, HI_A, LO_A}},
        // zero bytes and 0xff bytes in the value
        '{"init=", 33, 8'h00, END_NL, 1, '{DIR_INIT, ST_MALFORMED, 64'h0, 64'h0}},
        '{"bsv=", 5, 8'hff, END_EOD, 1, '{DIR_BSV, ST_MALFORMED, 64'h0, 64'h0}},
        // empty line closed by end of data
        '{"", 0, 8'h78, END_NL_EOD, 0, '0},
        // key compare is case sensitive
        '{"BSV=0123456789abcdef:FEDCBA9876543210", 0, 8'h78, END_NL, 1,
          '{DIR_OTHER, ST_OK, 64'h0, 64'h0}},
        '{"bsv=0123456789ABCDEF:fedcba9876543210", 0, 8'h78, END_NL, 0, '0},
        '{"init=0123456789abcdeg:FEDCBA9876543210", 0, 8'h78, END_NL, 0, '0}
    };

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [3:0]   m_tuser;

    // travel with each byte so the monitor sees the row that sent it
    bit           row_typed = 1'b0;
    line_report_t row_want  = '0;

    // parser model state
    logic        in_value;
    km_state_t   key_st;
    logic [7:0]  ln_len;
    logic [5:0]  val_idx;
    logic [63:0] id_acc [2];
    logic        val_err;

    line_report_t due_reports [$];
    int           mismatches    = 0;
    int           bytes_sent    = 0;
    int           cycle_cnt     = 0;
    int           src_idle_pct  = 0;
    int           snk_stall_pct = 0;

    config_line_id_parser_top #(
        .MAX_LINE (LINE_LIMIT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Line parser model
    // ---------------------------------------------------------------
    function automatic void clear_line();
        in_value  = 1'b0;
        key_st    = KM_START;
        ln_len    = '0;
        val_idx   = '0;
        id_acc[0] = '0;
        id_acc[1] = '0;
        val_err   = 1'b0;
    endfunction

    function automatic km_state_t key_next(input km_state_t k, input logic [7:0] c);
        case (k)
            KM_START: return (c == CH_LC_I) ? KM_I : ((c == CH_LC_B) ? KM_B : KM_MISS);
            KM_I:     return (c == CH_LC_N) ? KM_IN  : KM_MISS;
            KM_IN:    return (c == CH_LC_I) ? KM_INI : KM_MISS;
            KM_INI:   return (c == CH_LC_T) ? KM_INIT : KM_MISS;
            KM_B:     return (c == CH_LC_S) ? KM_BS  : KM_MISS;
            KM_BS:    return (c == CH_LC_V) ? KM_BSV : KM_MISS;
            default:  return KM_MISS;
        endcase
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        logic [4:0] h;
        int         slot;
        if (ln_len != LEN_SAT) ln_len = ln_len + 8'd1;
        if (!in_value)
        begin
            if (c == CH_EQ) in_value = 1'b1;
            else key_st = key_next(key_st, c);
            return;
        end
        if (val_idx >= ID_CHARS) return;
        h = hex_nibble(c);
        if (val_idx == COLON_POS)
        begin
            if (c != CH_COLON) val_err = 1'b1;
        end
        else if (h[4])
        begin
            val_err = 1'b1;
        end
        else
        begin
            slot = (val_idx < COLON_POS) ? 0 : 1;
            id_acc[slot] = {id_acc[slot][59:0], h[3:0]};
        end
        val_idx = val_idx + 6'd1;
    endfunction

    function automatic bit close_line(output line_report_t r);
        r = '0;
        if (ln_len == 0)
        begin
            clear_line();
            return 1'b0;
        end
        if (!in_value)              r.dir = DIR_NO_EQ;
        else if (key_st == KM_INIT) r.dir = DIR_INIT;
        else if (key_st == KM_BSV)  r.dir = DIR_BSV;
        else                        r.dir = DIR_OTHER;
        if (ln_len >= LINE_LIMIT)
            r.st = ST_TOO_LONG;
        else if ((r.dir == DIR_INIT || r.dir == DIR_BSV) && (val_err || val_idx < ID_CHARS))
            r.st = ST_MALFORMED;
        else
            r.st = ST_OK;
        if (r.st == ST_OK && (r.dir == DIR_INIT || r.dir == DIR_BSV))
        begin
            r.id_hi = id_acc[0];
            r.id_lo = id_acc[1];
        end
        clear_line();
        return 1'b1;
    endfunction

    // one accepted byte; returns 1 when it closes a non-empty line
    function automatic bit parse_byte(input logic [7:0] c, input logic eod,
                                      output line_report_t r);
        r = '0;
        if (c == CH_NL) return close_line(r);
        take_char(c);
        if (eod) return close_line(r);
        return 1'b0;
    endfunction

    initial clear_line();

    // ---------------------------------------------------------------
    // Sink: random stalls per the current phase
    // ---------------------------------------------------------------
    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= snk_stall_pct);

    task automatic note_mismatch(input string what, input line_report_t want,
                                 input line_report_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $write("mismatch (%s) at cycle %0d: exp dir=%0d st=%0d hi=%h lo=%h",
                   what, cycle_cnt, want.dir, want.st, want.id_hi, want.id_lo);
            $display(", got dir=%0d st=%0d hi=%h lo=%h",
                     got.dir, got.st, got.id_hi, got.id_lo);
        end
    endtask

    // ---------------------------------------------------------------
    // Monitor: check reports leaving, then model bytes entering.
    // Both sides are sampled at the edge where the transfer happens.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        line_report_t got;
        line_report_t want;
        line_report_t pred;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.dir   = m_tuser[1:0];
                got.st    = m_tuser[3:2];
                got.id_hi = m_tdata[63:0];
                got.id_lo = m_tdata[127:64];
                if (due_reports.size() == 0)
                begin
                    note_mismatch("no report due", '0, got);
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (got.dir !== want.dir || got.st !== want.st ||
                        got.id_hi !== want.id_hi || got.id_lo !== want.id_lo)
                        note_mismatch("wrong field", want, got);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (parse_byte(s_tdata, s_tlast, pred))
                    due_reports.push_back(row_typed ? row_want : pred);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Source side
    // ---------------------------------------------------------------
    // one byte transfer, with random gaps ahead of it
    task automatic put_byte(input logic [7:0] b, input logic last, input bit typed,
                            input line_report_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        s_tlast   <= last;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line(input logic [7:0] q[$], input line_end_t term, input bit typed,
                             input line_report_t want);
        for (int i = 0; i < q.size(); i++)
            put_byte(q[i], term == END_EOD && i == q.size() - 1, typed, want);
        if (term != END_EOD)
            put_byte(CH_NL, term == END_NL_EOD, typed, want);
    endtask

    function automatic void add_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 10) return 8'h30 + n;
        return (upper ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    // mostly well-formed directive lines with random ids, some corrupted,
    // truncated, padded or overlong; a few bursts of raw noise
    task automatic random_line();
        logic [7:0] q[$];
        logic [7:0] b;
        line_end_t  term;
        int         r;
        int         n;
        int         base;
        int         target;
        string      key_abc;
        key_abc = "ibnstvxA0:";
        r = $urandom_range(99);
        if (r < 6)
        begin
            // raw bytes, any value, newline and last flag included
            n = $urandom_range(16);
            repeat (n) put_byte(8'($urandom_range(255)), $urandom_range(15) == 0, 1'b0, '0);
            return;
        end
        r = $urandom_range(99);
        if (r < 42)      add_text(q, "init");
        else if (r < 80) add_text(q, "bsv");
        else
        begin
            n = (r < 92) ? $urandom_range(5) : $urandom_range(1, 10);
            repeat (n) q.push_back(key_abc[$urandom_range(key_abc.len() - 1)]);
        end
        if (r < 92)
        begin
            q.push_back(CH_EQ);
            base = q.size();
            for (int i = 0; i < ID_CHARS; i++)
            begin
                if (i == COLON_POS)
                    q.push_back(CH_COLON);
                else
                    q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end
            r = $urandom_range(99);
            if (r < 12)
            begin
                q[base + $urandom_range(ID_CHARS - 1)] = 8'($urandom_range(255));
            end
            else if (r < 20)
            begin
                n = $urandom_range(ID_CHARS - 1);
                while (q.size() > base + n) void'(q.pop_back());
            end
            if ($urandom_range(4) == 0)
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    b = 8'($urandom_range(255));
                    q.push_back(b == CH_NL ? CH_EQ : b);
                end
            end
        end
        // now and then a line near or far past the length limit
        if ($urandom_range(19) == 0)
        begin
            target = ($urandom_range(3) == 0) ? 300
                                              : $urandom_range(LINE_LIMIT - 2, LINE_LIMIT + 1);
            while (q.size() < target) q.push_back(8'($urandom_range(8'h20, 8'h7e)));
        end
        r = $urandom_range(9);
        term = (r < 8) ? END_NL : ((r == 8) ? END_EOD : END_NL_EOD);
        if (term == END_EOD && q.size() == 0) term = END_NL;
        send_line(q, term, 1'b0, '0);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [7:0] line_q[$];
        int         phase_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, no idling
        foreach (dir_rows[i])
        begin
            line_q.delete();
            add_text(line_q, dir_rows[i].text);
            repeat (dir_rows[i].pad) line_q.push_back(dir_rows[i].pad_ch);
            send_line(line_q, dir_rows[i].term, dir_rows[i].typed, dir_rows[i].want);
        end

        // random text through each idle phase
        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct  = SRC_IDLE[p];
            snk_stall_pct = SNK_STALL[p];
            phase_start   = bytes_sent;
            while (bytes_sent - phase_start < RAND_BYTES / 4) random_line();
        end
        s_tvalid <= 1'b0;

        // drain what is still queued inside the block
        while (due_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && due_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/clip_pkg.sv
rtl/clip_front.sv
rtl/clip_fifo.sv
rtl/clip_back.sv
rtl/config_line_id_parser_top.sv
tb/sv/tb_top.sv
